// ===== hdl/gle_pkg.sv =====
package gle_pkg;

  // Field widths
  localparam int ACT_W    = 2;
  localparam int CP_W     = 21;
  localparam int TEX_W    = 16;
  localparam int POS_W    = 24;
  localparam int SCALE_W  = 16;
  localparam int LH_W     = 23;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Signed product of a 17-bit texel value and a 17-bit non-negative scale
  localparam int PROD_W = TEX_W + SCALE_W + 1;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Actions
  localparam logic [ACT_W-1:0] ACT_STORE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DRAW   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CURSOR = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_QUAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STORED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CURSOR = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_H   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_H  = 2'd3;

  // Special code points
  localparam logic [CP_W-1:0] CP_NUL     = 21'd0;
  localparam logic [CP_W-1:0] CP_NEWLINE = 21'd10;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  // One glyph table entry
  typedef struct packed {
    logic [CP_W-1:0]  key;
    logic [TEX_W-1:0] tex_x;
    logic [TEX_W-1:0] tex_y;
    logic [TEX_W-1:0] tex_w;
    logic [TEX_W-1:0] bearing;
    logic [TEX_W-1:0] advance;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_MUL_B,
    ST_ADD_B,
    ST_MUL_A,
    ST_ADD_A,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/glyph_layout_engine_unit.sv =====
// Latency: set cursor, newline, NUL, skipped and unused items load the result one cycle
// after acceptance. Stores and lookups scan the table one entry per cycle through the single
// memory read port; for a quad, one shared multiplier and saturating adder then scale and
// add the bearing and then the advance onto the cursor x to place it.
// Throughput: one item in work at a time; the next item is taken the cycle after the result
// loads, later while a waiting result stalls. Reset (synchronous, active low) clears state.
module glyph_layout_engine_unit #(
  parameter int GLYPH_ENTRIES   = 128,
  parameter int POS_FRAC_BITS   = 8,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gle_pkg::ACT_W-1:0]             in_action,
  input  logic [gle_pkg::CP_W-1:0]              in_code_point,
  input  logic                                  in_last_in_string,
  input  logic [gle_pkg::TEX_W-1:0]             in_glyph_x,
  input  logic [gle_pkg::TEX_W-1:0]             in_glyph_y,
  input  logic [gle_pkg::TEX_W-1:0]             in_glyph_w,
  input  logic signed [gle_pkg::TEX_W-1:0]      in_glyph_bearing,
  input  logic [gle_pkg::TEX_W-1:0]             in_glyph_advance,
  input  logic signed [gle_pkg::POS_W-1:0]      in_new_x,
  input  logic signed [gle_pkg::POS_W-1:0]      in_new_y,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [gle_pkg::KIND_W-1:0]            out_kind,
  output logic signed [gle_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [gle_pkg::POS_W-1:0]      out_pos_y,
  output logic [gle_pkg::TEX_W-1:0]             out_tex_u,
  output logic [gle_pkg::TEX_W-1:0]             out_tex_v,
  output logic [gle_pkg::TEX_W-1:0]             out_tex_w,
  output logic [gle_pkg::TEX_W-1:0]             out_tex_h,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gle_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gle_pkg::CFG_DAT_W-1:0]         cfg_data
);

  localparam int IDX_W = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GLYPH_ENTRIES - 1);

  // Fraction conversion from scale to position format
  localparam int FRAC_D = SCALE_FRAC_BITS - POS_FRAC_BITS;
  localparam int SHR    = (FRAC_D > 0) ? FRAC_D : 0;
  localparam int SHL    = (FRAC_D < 0) ? -FRAC_D : 0;
  localparam int RND_SH = (SHR > 0) ? SHR - 1 : 0;
  localparam int SUM_W  = gle_pkg::PROD_W + SHL + 2;
  localparam logic signed [SUM_W-1:0] RND =
    (SHR > 0) ? (SUM_W'(1) << RND_SH) : '0;

  // State and configuration
  gle_pkg::state_t                    state_r, state_nxt;
  logic [gle_pkg::SCALE_W-1:0]        scale_r;
  logic signed [gle_pkg::POS_W-1:0]   margin_r;
  logic [gle_pkg::LH_W-1:0]           lheight_r;
  logic [gle_pkg::TEX_W-1:0]          theight_r;
  logic signed [gle_pkg::POS_W-1:0]   cursor_x_r;
  logic signed [gle_pkg::POS_W-1:0]   cursor_y_r;
  logic                               skip_r;
  logic [GLYPH_ENTRIES-1:0]           valid_r;

  // Item latches
  logic [gle_pkg::ACT_W-1:0]          act_r;
  logic [gle_pkg::CP_W-1:0]           cp_r;
  gle_pkg::entry_t                    st_ent_r;
  logic [gle_pkg::KIND_W-1:0]         kind_r;

  // Glyph memory and scan pipeline
  gle_pkg::entry_t                    mem [GLYPH_ENTRIES];
  gle_pkg::entry_t                    rd_data_r;
  logic [IDX_W-1:0]                   rd_idx_r;
  logic                               issue_on_r;
  logic                               chk_vld_r;
  logic [IDX_W-1:0]                   chk_idx_r;
  logic                               hit_r;
  logic [IDX_W-1:0]                   hit_idx_r;
  gle_pkg::entry_t                    hit_ent_r;
  logic                               free_r;
  logic [IDX_W-1:0]                   free_idx_r;

  // Arithmetic
  logic signed [gle_pkg::PROD_W-1:0]  prod_r;
  logic signed [gle_pkg::POS_W-1:0]   px_r;

  // Output register
  logic                               out_valid_r;
  logic [gle_pkg::KIND_W-1:0]         out_kind_r;
  logic signed [gle_pkg::POS_W-1:0]   out_pos_x_r;
  logic signed [gle_pkg::POS_W-1:0]   out_pos_y_r;
  logic [gle_pkg::TEX_W-1:0]          out_tex_u_r;
  logic [gle_pkg::TEX_W-1:0]          out_tex_v_r;
  logic [gle_pkg::TEX_W-1:0]          out_tex_w_r;
  logic [gle_pkg::TEX_W-1:0]          out_tex_h_r;

  // Control strobes
  logic idle_st, scan_st, resolve_st, mul_st, mul_adv, add_st, add_adv, done_st;
  logic accept, done_fire, need_scan, chk_valid_bit, match, scan_end;
  logic mem_we;
  logic [IDX_W-1:0] mem_wa;

  assign accept        = in_valid && in_ready;
  assign done_fire     = done_st && (!out_valid_r || out_ready);
  assign need_scan     = (in_action == gle_pkg::ACT_STORE) ||
                         ((in_action == gle_pkg::ACT_DRAW) && !skip_r &&
                          !(in_code_point inside {gle_pkg::CP_NUL, gle_pkg::CP_NEWLINE}));
  assign chk_valid_bit = valid_r[chk_idx_r];
  assign match         = scan_st && chk_vld_r && chk_valid_bit && (rd_data_r.key == cp_r);
  assign scan_end      = match || (chk_vld_r && (chk_idx_r == LAST_IDX));
  assign mem_we        = resolve_st && (act_r == gle_pkg::ACT_STORE) && (hit_r || free_r);
  assign mem_wa        = hit_r ? hit_idx_r : free_idx_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gle_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = need_scan ? gle_pkg::ST_SCAN : gle_pkg::ST_DONE;
        end
      end
      gle_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = gle_pkg::ST_RESOLVE;
        end
      end
      gle_pkg::ST_RESOLVE: begin
        state_nxt = ((act_r == gle_pkg::ACT_DRAW) && hit_r) ? gle_pkg::ST_MUL_B
                                                            : gle_pkg::ST_DONE;
      end
      gle_pkg::ST_MUL_B: state_nxt = gle_pkg::ST_ADD_B;
      gle_pkg::ST_ADD_B: state_nxt = gle_pkg::ST_MUL_A;
      gle_pkg::ST_MUL_A: state_nxt = gle_pkg::ST_ADD_A;
      gle_pkg::ST_ADD_A: state_nxt = gle_pkg::ST_DONE;
      gle_pkg::ST_DONE: begin
        if (done_fire) begin
          state_nxt = gle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gle_pkg::ST_IDLE;
    endcase
  end

  // State decode
  always_comb begin
    idle_st    = 1'b0;
    scan_st    = 1'b0;
    resolve_st = 1'b0;
    mul_st     = 1'b0;
    mul_adv    = 1'b0;
    add_st     = 1'b0;
    add_adv    = 1'b0;
    done_st    = 1'b0;
    case (state_r)
      gle_pkg::ST_IDLE:    idle_st = 1'b1;
      gle_pkg::ST_SCAN:    scan_st = 1'b1;
      gle_pkg::ST_RESOLVE: resolve_st = 1'b1;
      gle_pkg::ST_MUL_B:   mul_st = 1'b1;
      gle_pkg::ST_ADD_B:   add_st = 1'b1;
      gle_pkg::ST_MUL_A: begin
        mul_st  = 1'b1;
        mul_adv = 1'b1;
      end
      gle_pkg::ST_ADD_A: begin
        add_st  = 1'b1;
        add_adv = 1'b1;
      end
      gle_pkg::ST_DONE:    done_st = 1'b1;
      default:             idle_st = 1'b0;
    endcase
  end

  // Shared multiplier: bearing or advance times scale
  logic signed [gle_pkg::TEX_W:0]      mul_a;
  logic signed [gle_pkg::SCALE_W:0]    mul_b;
  logic signed [gle_pkg::PROD_W:0]     prod_full;

  assign mul_a = mul_adv ? $signed({1'b0, hit_ent_r.advance})
                         : $signed({hit_ent_r.bearing[gle_pkg::TEX_W-1], hit_ent_r.bearing});
  assign mul_b = $signed({1'b0, scale_r});
  assign prod_full = mul_a * mul_b;

  // Shared rounding add with saturation onto the cursor x
  logic signed [SUM_W-1:0]           p_ext, p_conv, cx_ext, x_sum;
  logic signed [gle_pkg::POS_W-1:0]  x_sat;
  logic [SUM_W-gle_pkg::POS_W:0]     x_hi;

  assign p_ext  = SUM_W'(prod_r);
  assign p_conv = ((p_ext + RND) >>> SHR) <<< SHL;
  assign cx_ext = SUM_W'(cursor_x_r);
  assign x_sum  = cx_ext + p_conv;
  assign x_hi   = x_sum[SUM_W-1:gle_pkg::POS_W-1];
  assign x_sat  = ((&x_hi) || !(|x_hi)) ? x_sum[gle_pkg::POS_W-1:0]
                : (x_sum[SUM_W-1] ? gle_pkg::POS_MIN : gle_pkg::POS_MAX);

  // Newline y advance with saturation
  logic signed [gle_pkg::POS_W:0]    y_sum;
  logic signed [gle_pkg::POS_W-1:0]  y_sat;

  assign y_sum = $signed({cursor_y_r[gle_pkg::POS_W-1], cursor_y_r}) +
                 $signed({2'b00, lheight_r});
  assign y_sat = (y_sum[gle_pkg::POS_W] != y_sum[gle_pkg::POS_W-1])
               ? (y_sum[gle_pkg::POS_W] ? gle_pkg::POS_MIN : gle_pkg::POS_MAX)
               : y_sum[gle_pkg::POS_W-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gle_pkg::ST_IDLE;
      scale_r     <= gle_pkg::SCALE_RESET;
      margin_r    <= '0;
      lheight_r   <= '0;
      theight_r   <= '0;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      skip_r      <= 1'b0;
      valid_r     <= '0;
      issue_on_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          gle_pkg::CFG_SCALE:   scale_r   <= cfg_data[gle_pkg::SCALE_W-1:0];
          gle_pkg::CFG_MARGIN:  margin_r  <= $signed(cfg_data[gle_pkg::POS_W-1:0]);
          gle_pkg::CFG_LINE_H:  lheight_r <= cfg_data[gle_pkg::LH_W-1:0];
          gle_pkg::CFG_TEXEL_H: theight_r <= cfg_data[gle_pkg::TEX_W-1:0];
          default:              scale_r   <= scale_r;
        endcase
      end

      // cursor and skip updates that need no table lookup
      if (accept) begin
        case (in_action)
          gle_pkg::ACT_DRAW: begin
            if (skip_r) begin
              if (in_last_in_string) begin
                skip_r <= 1'b0;
              end
            end else if (in_code_point == gle_pkg::CP_NUL) begin
              skip_r <= !in_last_in_string;
            end else if (in_code_point == gle_pkg::CP_NEWLINE) begin
              cursor_x_r <= margin_r;
              cursor_y_r <= y_sat;
            end
          end
          gle_pkg::ACT_CURSOR: begin
            cursor_x_r <= in_new_x;
            cursor_y_r <= in_new_y;
          end
          default: skip_r <= skip_r;
        endcase
      end

      // cursor advance after a drawn glyph
      if (add_adv) begin
        cursor_x_r <= x_sat;
      end

      // scan issue side
      if (accept) begin
        issue_on_r <= need_scan;
        chk_vld_r  <= 1'b0;
      end else if (scan_st) begin
        chk_vld_r <= issue_on_r;
        if (rd_idx_r == LAST_IDX) begin
          issue_on_r <= 1'b0;
        end
      end else begin
        issue_on_r <= 1'b0;
        chk_vld_r  <= 1'b0;
      end

      // new entry becomes valid
      if (mem_we) begin
        valid_r[mem_wa] <= 1'b1;
      end

      // result register
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r            <= in_action;
      cp_r             <= in_code_point;
      st_ent_r.key     <= in_code_point;
      st_ent_r.tex_x   <= in_glyph_x;
      st_ent_r.tex_y   <= in_glyph_y;
      st_ent_r.tex_w   <= in_glyph_w;
      st_ent_r.bearing <= in_glyph_bearing;
      st_ent_r.advance <= in_glyph_advance;
      kind_r           <= (in_action == gle_pkg::ACT_CURSOR) ? gle_pkg::KIND_CURSOR
                                                             : gle_pkg::KIND_NONE;
      rd_idx_r         <= '0;
      hit_r            <= 1'b0;
      free_r           <= 1'b0;
    end else if (scan_st) begin
      if (issue_on_r && (rd_idx_r != LAST_IDX)) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= chk_idx_r;
        hit_ent_r <= rd_data_r;
      end
      if (chk_vld_r && !chk_valid_bit && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
    end else if (resolve_st) begin
      if (act_r == gle_pkg::ACT_STORE) begin
        kind_r <= (hit_r || free_r) ? gle_pkg::KIND_STORED : gle_pkg::KIND_FULL;
      end else if (hit_r) begin
        kind_r <= gle_pkg::KIND_QUAD;
      end
    end
    chk_idx_r <= rd_idx_r;

    if (mul_st) begin
      prod_r <= $signed(prod_full[gle_pkg::PROD_W-1:0]);
    end
    if (add_st && !add_adv) begin
      px_r <= x_sat;
    end

    // load the result; non-quad kinds carry zero fields
    if (done_fire) begin
      out_kind_r <= kind_r;
      if (kind_r == gle_pkg::KIND_QUAD) begin
        out_pos_x_r <= px_r;
        out_pos_y_r <= cursor_y_r;
        out_tex_u_r <= hit_ent_r.tex_x;
        out_tex_v_r <= hit_ent_r.tex_y;
        out_tex_w_r <= hit_ent_r.tex_w;
        out_tex_h_r <= theight_r;
      end else begin
        out_pos_x_r <= '0;
        out_pos_y_r <= '0;
        out_tex_u_r <= '0;
        out_tex_v_r <= '0;
        out_tex_w_r <= '0;
        out_tex_h_r <= '0;
      end
    end
  end

  // Glyph memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= st_ent_r;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  // no item or register write is taken while reset is held
  assign in_ready  = idle_st && rst_n;
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;
  assign out_tex_u = out_tex_u_r;
  assign out_tex_v = out_tex_v_r;
  assign out_tex_w = out_tex_w_r;
  assign out_tex_h = out_tex_h_r;

endmodule
